// File: rtl/assert_macros.svh
// Assertion macros for the port-level checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while in reset
`define MAT4M_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while in reset
`define MAT4M_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define MAT4M_ASSERT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mat4m_pkg.sv
`timescale 1ns / 1ps
// Shared constants, function codes and control struct for the 4x4 matrix unit.
// No dependencies.
package mat4m_pkg;

    localparam int DIM            = 4;
    localparam int FIELD_W        = 32;
    localparam int COL_W          = 2;
    localparam int FUNC_W         = 2;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ELEM_WIDTH_DEF = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_MUL    = 2'd1,
        FUNC_COMMIT = 2'd2
    } t_func;

    // state update request, qualified with the pipeline advance
    typedef struct packed {
        logic             load;
        logic             mul;
        logic             commit;
        logic [COL_W-1:0] col;
    } t_upd;

endpackage

// File: rtl/mat4m_in_if.sv
`timescale 1ns / 1ps
// Input channel: one column beat with its function code.
// Depends on mat4m_pkg.
interface mat4m_in_if;
    import mat4m_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic [COL_W-1:0]          column;
    logic signed [FIELD_W-1:0] elem_x;
    logic signed [FIELD_W-1:0] elem_y;
    logic signed [FIELD_W-1:0] elem_z;
    logic signed [FIELD_W-1:0] elem_w;

    modport source (output valid, func, column, elem_x, elem_y, elem_z, elem_w,
                    input ready);
    modport sink   (input valid, func, column, elem_x, elem_y, elem_z, elem_w,
                    output ready);
endinterface

// File: rtl/mat4m_out_if.sv
`timescale 1ns / 1ps
// Output channel: one result column beat with saturation flag.
// Depends on mat4m_pkg.
interface mat4m_out_if;
    import mat4m_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [COL_W-1:0]          out_column;
    logic signed [FIELD_W-1:0] res_x;
    logic signed [FIELD_W-1:0] res_y;
    logic signed [FIELD_W-1:0] res_z;
    logic signed [FIELD_W-1:0] res_w;
    logic                      saturated;

    modport source (output valid, out_column, res_x, res_y, res_z, res_w, saturated,
                    input ready);
    modport sink   (input valid, out_column, res_x, res_y, res_z, res_w, saturated,
                    output ready);
endinterface

// File: rtl/mat4m_lane.sv
`timescale 1ns / 1ps
// One result row: four signed products, exact sum, floor shift and clamp.
// Depends on mat4m_pkg.
module mat4m_lane #(
    parameter int FRAC_BITS  = mat4m_pkg::FRAC_BITS_DEF,
    parameter int ELEM_WIDTH = mat4m_pkg::ELEM_WIDTH_DEF
) (
    input  logic [ELEM_WIDTH-1:0] i_row [mat4m_pkg::DIM],
    input  logic [ELEM_WIDTH-1:0] i_vec [mat4m_pkg::DIM],
    output logic [ELEM_WIDTH-1:0] o_res,
    output logic                  o_sat
);
    import mat4m_pkg::*;

    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int TOP_W  = SUM_W - ELEM_WIDTH + 1;
    localparam logic [ELEM_WIDTH-1:0] MAX_V = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic [ELEM_WIDTH-1:0] MIN_V = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    logic signed [ELEM_WIDTH-1:0] w_a    [DIM];
    logic signed [ELEM_WIDTH-1:0] w_b    [DIM];
    logic signed [PROD_W-1:0]     w_prod [DIM];
    logic signed [SUM_W-1:0]      w_sum;
    logic signed [SUM_W-1:0]      w_shift;
    logic [TOP_W-1:0]             w_top;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < DIM; k++) begin
            w_a[k]    = i_row[k];
            w_b[k]    = i_vec[k];
            w_prod[k] = w_a[k] * w_b[k];
            w_sum     = w_sum + SUM_W'(w_prod[k]);
        end
        // arithmetic shift floors toward minus infinity
        w_shift = w_sum >>> FRAC_BITS;
        // in range when everything above the result sign bit copies it
        w_top   = w_shift[SUM_W-1:ELEM_WIDTH-1];
        if ((&w_top) || !(|w_top)) begin
            o_res = w_shift[ELEM_WIDTH-1:0];
            o_sat = 1'b0;
        end else begin
            o_res = w_sum[SUM_W-1] ? MIN_V : MAX_V;
            o_sat = 1'b1;
        end
    end

endmodule

// File: rtl/mat4m_state.sv
`timescale 1ns / 1ps
// Matrix L (identity after reset) and the pending product columns.
// Depends on mat4m_pkg.
module mat4m_state #(
    parameter int FRAC_BITS  = mat4m_pkg::FRAC_BITS_DEF,
    parameter int ELEM_WIDTH = mat4m_pkg::ELEM_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mat4m_pkg::t_upd       i_upd,
    input  logic [ELEM_WIDTH-1:0] i_vec  [mat4m_pkg::DIM],
    input  logic [ELEM_WIDTH-1:0] i_prod [mat4m_pkg::DIM],
    output logic [ELEM_WIDTH-1:0] o_mat  [mat4m_pkg::DIM][mat4m_pkg::DIM]
);
    import mat4m_pkg::*;

    localparam logic [ELEM_WIDTH-1:0] ONE = ELEM_WIDTH'(1) << FRAC_BITS;

    // indexed [column][row]
    logic [ELEM_WIDTH-1:0] r_mat  [DIM][DIM];
    logic [ELEM_WIDTH-1:0] r_pend [DIM][DIM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < DIM; c++) begin
                for (int r = 0; r < DIM; r++) begin
                    r_mat[c][r] <= (c == r) ? ONE : '0;
                end
            end
        end else begin
            for (int c = 0; c < DIM; c++) begin
                for (int r = 0; r < DIM; r++) begin
                    if (i_upd.load && i_upd.col == COL_W'(c)) begin
                        r_mat[c][r] <= i_vec[r];
                    end else if (i_upd.commit) begin
                        // the column being produced this beat bypasses the pending store
                        r_mat[c][r] <= (i_upd.col == COL_W'(c)) ? i_prod[r] : r_pend[c][r];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.mul || i_upd.commit) begin
            for (int r = 0; r < DIM; r++) begin
                r_pend[i_upd.col][r] <= i_prod[r];
            end
        end
    end

    assign o_mat = r_mat;

endmodule

// File: rtl/mat4_column_major_multiply.sv
`timescale 1ns / 1ps
// 4x4 column-major matrix unit, one column per beat.
// Stage 1 registers the beat, four row lanes compute, stage 2 registers the result.
// Throughput: one beat per cycle unless output stalls; single compute stage sets it.
// Reset (sync, active low): matrix returns to identity, both stages empty.
// Depends on mat4m_pkg, mat4m_in_if, mat4m_out_if, mat4m_lane, mat4m_state.
module mat4_column_major_multiply #(
    parameter int FRAC_BITS  = mat4m_pkg::FRAC_BITS_DEF,
    parameter int ELEM_WIDTH = mat4m_pkg::ELEM_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mat4m_in_if.sink    i_in,
    mat4m_out_if.source o_out
);
    import mat4m_pkg::*;

    logic                  r_s1_valid;
    logic [FUNC_W-1:0]     r_s1_func;
    logic [COL_W-1:0]      r_s1_col;
    logic [ELEM_WIDTH-1:0] r_s1_vec [DIM];
    logic [ELEM_WIDTH-1:0] w_in_vec [DIM];

    logic                  r_s2_valid;
    logic [COL_W-1:0]      r_s2_col;
    logic [FIELD_W-1:0]    r_s2_res [DIM];
    logic                  r_s2_sat;
    logic [FIELD_W-1:0]    n_res    [DIM];
    logic                  n_sat;

    logic [ELEM_WIDTH-1:0] w_mat  [DIM][DIM];
    logic [ELEM_WIDTH-1:0] w_row  [DIM][DIM];
    logic [ELEM_WIDTH-1:0] w_prod [DIM];
    logic [DIM-1:0]        w_sat;
    logic                  w_s2_free;
    logic                  w_adv;
    t_func                 w_func;
    t_upd                  w_upd;

    assign w_s2_free   = !r_s2_valid || o_out.ready;
    assign w_adv       = r_s1_valid && w_s2_free;
    assign i_in.ready  = !r_s1_valid || w_adv;

    assign w_in_vec[0] = ELEM_WIDTH'($unsigned(i_in.elem_x));
    assign w_in_vec[1] = ELEM_WIDTH'($unsigned(i_in.elem_y));
    assign w_in_vec[2] = ELEM_WIDTH'($unsigned(i_in.elem_z));
    assign w_in_vec[3] = ELEM_WIDTH'($unsigned(i_in.elem_w));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_func <= i_in.func;
            r_s1_col  <= i_in.column;
            r_s1_vec  <= w_in_vec;
        end
    end

    // row r of L gathered across the columns
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int k = 0; k < DIM; k++) begin
                w_row[r][k] = w_mat[k][r];
            end
        end
    end

    for (genvar r = 0; r < DIM; r++) begin : g_lane
        mat4m_lane #(
            .FRAC_BITS  (FRAC_BITS),
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_lane (
            .i_row (w_row[r]),
            .i_vec (r_s1_vec),
            .o_res (w_prod[r]),
            .o_sat (w_sat[r])
        );
    end

    assign w_func = t_func'(r_s1_func);

    always_comb begin
        w_upd.load   = w_adv && (w_func == FUNC_LOAD);
        w_upd.mul    = w_adv && (w_func == FUNC_MUL);
        w_upd.commit = w_adv && (w_func == FUNC_COMMIT);
        w_upd.col    = r_s1_col;
    end

    mat4m_state #(
        .FRAC_BITS  (FRAC_BITS),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_upd),
        .i_vec   (r_s1_vec),
        .i_prod  (w_prod),
        .o_mat   (w_mat)
    );

    always_comb begin
        n_sat = 1'b0;
        for (int r = 0; r < DIM; r++) begin
            n_res[r] = '0;
        end
        unique case (w_func) inside
            FUNC_LOAD: begin
                for (int r = 0; r < DIM; r++) begin
                    n_res[r] = FIELD_W'(r_s1_vec[r]);
                end
            end
            FUNC_MUL, FUNC_COMMIT: begin
                for (int r = 0; r < DIM; r++) begin
                    n_res[r] = FIELD_W'(w_prod[r]);
                end
                n_sat = |w_sat;
            end
            default: begin
                n_sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_col <= r_s1_col;
            r_s2_res <= n_res;
            r_s2_sat <= n_sat;
        end
    end

    assign o_out.valid      = r_s2_valid;
    assign o_out.out_column = r_s2_col;
    assign o_out.res_x      = r_s2_res[0];
    assign o_out.res_y      = r_s2_res[1];
    assign o_out.res_z      = r_s2_res[2];
    assign o_out.res_w      = r_s2_res[3];
    assign o_out.saturated  = r_s2_sat;

endmodule

// File: rtl/mat4m_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the matrix unit, bound to the top level.
// Depends on assert_macros.svh and mat4m_pkg.
`include "assert_macros.svh"

module mat4m_checker #(
    parameter int ELEM_WIDTH = mat4m_pkg::ELEM_WIDTH_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [mat4m_pkg::COL_W-1:0]         i_out_column,
    input logic signed [mat4m_pkg::FIELD_W-1:0] i_res_x,
    input logic signed [mat4m_pkg::FIELD_W-1:0] i_res_y,
    input logic signed [mat4m_pkg::FIELD_W-1:0] i_res_z,
    input logic signed [mat4m_pkg::FIELD_W-1:0] i_res_w,
    input logic                                i_saturated
);
    import mat4m_pkg::*;

    localparam logic [FIELD_W-1:0] CLAMP_MAX = FIELD_W'({1'b0, {(ELEM_WIDTH-1){1'b1}}});
    localparam logic [FIELD_W-1:0] CLAMP_MIN = FIELD_W'({1'b1, {(ELEM_WIDTH-1){1'b0}}});

    logic w_any_clamp;

    assign w_any_clamp =
        (i_res_x == CLAMP_MAX) || (i_res_x == CLAMP_MIN) ||
        (i_res_y == CLAMP_MAX) || (i_res_y == CLAMP_MIN) ||
        (i_res_z == CLAMP_MAX) || (i_res_z == CLAMP_MIN) ||
        (i_res_w == CLAMP_MAX) || (i_res_w == CLAMP_MIN);

    // a stalled result beat holds
    `MAT4M_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_column) && $stable(i_res_x) && $stable(i_res_y) && $stable(i_res_z) && $stable(i_res_w) && $stable(i_saturated), "result beat changed while stalled")

    // nothing offered right after reset
    `MAT4M_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, !i_out_valid, "result offered after reset")

    // an empty output stage never blocks the input
    `MAT4M_ASSERT_IMP(a_in_flow, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input stalled with empty output")

    // a saturated beat carries at least one clamp value
    `MAT4M_ASSERT_IMP(a_sat_clamp, i_clk, i_rst_n, i_out_valid && i_saturated, w_any_clamp, "saturated flag without clamped element")

    // input taken while output stalled must not lose the stalled result beat
    `MAT4M_ASSERT_NXT(a_in_backpress, i_clk, i_rst_n, i_in_valid && i_in_ready && i_out_valid && !i_out_ready, !i_out_ready || i_out_valid, "result lost under back-pressure")

endmodule

bind mat4_column_major_multiply mat4m_checker #(
    .ELEM_WIDTH (ELEM_WIDTH)
) u_mat4m_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_column (o_out.out_column),
    .i_res_x      (o_out.res_x),
    .i_res_y      (o_out.res_y),
    .i_res_z      (o_out.res_z),
    .i_res_w      (o_out.res_w),
    .i_saturated  (o_out.saturated)
);

// File: tb/mat4m_column_check.sv
`timescale 1ns / 1ps
// Column checker for the 4x4 matrix unit: mirrors the matrix and the pending
// product, predicts each result beat and compares it in order of arrival.
// Depends on mat4m_pkg, mat4m_in_if and mat4m_out_if.
module mat4m_column_check (
    input  logic i_clk,
    input  logic i_rst_n,
    mat4m_in_if  i_in_ch,
    mat4m_out_if i_out_ch,
    output int   o_fail_count,
    output int   o_outstanding
);
    import mat4m_pkg::*;

    localparam int ELEM_W = ELEM_WIDTH_DEF;
    localparam int FRAC   = FRAC_BITS_DEF;
    localparam int CELLS  = DIM * DIM;
    // four full products need two bits of headroom; keep a little more
    localparam int ACC_W  = 2 * ELEM_W + 4;
    localparam longint ELEM_MAX = (longint'(1) <<< (ELEM_W - 1)) - 1;
    localparam longint ELEM_MIN = -(longint'(1) <<< (ELEM_W - 1));
    localparam logic signed [ELEM_W-1:0] UNITY = ELEM_W'(1) << FRAC;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] z;
        logic [FIELD_W-1:0] w;
        logic               saturated;
    } column_beat_t;

    // entry (row r, column c) at c*DIM + r
    logic signed [ELEM_W-1:0] matrix_q  [CELLS];
    logic signed [ELEM_W-1:0] product_q [CELLS];
    column_beat_t             expected_beats [$];
    int                       mismatches = 0;

    function automatic column_beat_t predict_column(input logic [FUNC_W-1:0] fn,
                                                    input logic [COL_W-1:0] col,
                                                    input logic [FIELD_W-1:0] ex, ey, ez, ew);
        logic signed [ELEM_W-1:0] vec     [DIM];
        logic signed [ELEM_W-1:0] row_val [DIM];
        logic signed [ACC_W-1:0]  acc;
        logic signed [ACC_W-1:0]  lhs;
        logic signed [ACC_W-1:0]  rhs;
        logic signed [ACC_W-1:0]  scaled;
        logic                     clipped;
        column_beat_t             beat;
        int                       r;
        int                       k;
        vec[0]  = ex;
        vec[1]  = ey;
        vec[2]  = ez;
        vec[3]  = ew;
        clipped = 1'b0;
        case (fn)
            FUNC_LOAD: begin
                for (r = 0; r < DIM; r++) begin
                    matrix_q[col * DIM + r] = vec[r];
                    row_val[r]              = vec[r];
                end
            end
            FUNC_MUL, FUNC_COMMIT: begin
                for (r = 0; r < DIM; r++) begin
                    acc = '0;
                    for (k = 0; k < DIM; k++) begin
                        lhs = matrix_q[k * DIM + r];
                        rhs = vec[k];
                        acc = acc + lhs * rhs;
                    end
                    // floor shift, then clamp to the element range
                    scaled = acc >>> FRAC;
                    if (scaled > ELEM_MAX) begin
                        row_val[r] = ELEM_W'(ELEM_MAX);
                        clipped    = 1'b1;
                    end else if (scaled < ELEM_MIN) begin
                        row_val[r] = ELEM_W'(ELEM_MIN);
                        clipped    = 1'b1;
                    end else begin
                        row_val[r] = scaled[ELEM_W-1:0];
                    end
                    product_q[col * DIM + r] = row_val[r];
                end
                if (fn == FUNC_COMMIT) begin
                    for (r = 0; r < CELLS; r++) matrix_q[r] = product_q[r];
                end
            end
            default: begin
                for (r = 0; r < DIM; r++) row_val[r] = '0;
            end
        endcase
        beat.column    = col;
        beat.x         = row_val[0];
        beat.y         = row_val[1];
        beat.z         = row_val[2];
        beat.w         = row_val[3];
        beat.saturated = clipped;
        return beat;
    endfunction

    task automatic compare_field(input string name, input logic [FIELD_W-1:0] want, got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : track_columns
        column_beat_t want;
        int           idx;
        if (!i_rst_n) begin
            for (idx = 0; idx < CELLS; idx++) begin
                matrix_q[idx]  = (idx % (DIM + 1) == 0) ? UNITY : '0;
                product_q[idx] = '0;
            end
            expected_beats.delete();
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                expected_beats.push_back(predict_column(i_in_ch.func, i_in_ch.column,
                                                        i_in_ch.elem_x, i_in_ch.elem_y,
                                                        i_in_ch.elem_z, i_in_ch.elem_w));
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat for column %0d with nothing expected",
                           i_out_ch.out_column);
                    mismatches++;
                end else begin
                    want = expected_beats.pop_front();
                    compare_field("out_column", FIELD_W'(want.column),
                                  FIELD_W'(i_out_ch.out_column));
                    compare_field("res_x", want.x, i_out_ch.res_x);
                    compare_field("res_y", want.y, i_out_ch.res_y);
                    compare_field("res_z", want.z, i_out_ch.res_z);
                    compare_field("res_w", want.w, i_out_ch.res_w);
                    compare_field("saturated", FIELD_W'(want.saturated),
                                  FIELD_W'(i_out_ch.saturated));
                end
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= expected_beats.size();
    end

endmodule

// File: tb/tb_mat4_column_major_multiply.sv
`timescale 1ns / 1ps
// Testbench top for the 4x4 matrix unit: clock, reset, column stimulus,
// result-side stalls, watchdog and verdict.
// Depends on mat4m_pkg, both channel interfaces, mat4m_column_check and the block.
module tb_mat4_column_major_multiply;
    import mat4m_pkg::*;

    // selector with no operation behind it; the block must still answer it
    localparam logic [FUNC_W-1:0]         FUNC_SPARE     = 2'd3;
    localparam logic signed [FIELD_W-1:0] ELEM_HI        = 32'sh7fff_ffff;
    localparam logic signed [FIELD_W-1:0] ELEM_LO        = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] UNITY          = 32'sh0001_0000;
    localparam int                        RANDOM_BEATS   = 1700;
    localparam int                        DRAIN_EVERY    = 400;
    localparam int                        STALL_AT_BEAT  = 700;
    localparam int                        HOLD_CYCLES    = 200;
    localparam int                        TAIL_CYCLES    = 8;
    localparam int                        WATCHDOG_LIMIT = 2000;

    logic           i_clk;
    logic           i_rst_n;
    int             fail_count;
    int             outstanding;
    int             beats_sent   = 0;
    int             quiet_beats  = 0;
    int             stuck_cycles = 0;
    logic [DIM-1:0] pending_cols = '0;
    bit             hold_request = 1'b0;

    mat4m_in_if  in_ch ();
    mat4m_out_if out_ch ();

    mat4_column_major_multiply dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    mat4m_column_check column_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(1, 2);
        if (pick < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    // mostly moderate Q16.16 values, some full-range words and corner values
    function automatic logic [FIELD_W-1:0] rand_elem();
        logic signed [FIELD_W-1:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0:       return ELEM_HI;
                    1:       return ELEM_LO;
                    2:       return '0;
                    3:       return '1;
                    4:       return UNITY;
                    default: return -UNITY;
                endcase
            end
            1, 2:    return raw;
            default: return raw >>> $urandom_range(8, 20);
        endcase
    endfunction

    // a commit may only fire once every pending column has been produced
    function automatic bit commit_allowed(input logic [COL_W-1:0] col);
        return (pending_cols | (DIM'(1) << col)) == {DIM{1'b1}};
    endfunction

    task automatic send_beat(input logic [FUNC_W-1:0] fn, input logic [COL_W-1:0] col,
                             input logic [FIELD_W-1:0] ex, ey, ez, ew);
        int gap;
        if (quiet_beats > 0) begin
            quiet_beats--;
            gap = 0;
        end else if ($urandom_range(0, 99) < 3) begin
            quiet_beats = $urandom_range(30, 100);
            gap         = 0;
        end else if ($urandom_range(0, 99) < 55) begin
            gap = 0;
        end else begin
            gap = idle_len();
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.func   <= fn;
        in_ch.column <= col;
        in_ch.elem_x <= ex;
        in_ch.elem_y <= ey;
        in_ch.elem_z <= ez;
        in_ch.elem_w <= ew;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (fn == FUNC_MUL || fn == FUNC_COMMIT) pending_cols[col] = 1'b1;
        beats_sent++;
    endtask

    task automatic send_rand(input logic [FUNC_W-1:0] fn, input logic [COL_W-1:0] col);
        send_beat(fn, col, rand_elem(), rand_elem(), rand_elem(), rand_elem());
    endtask

    // stop offering and wait until every predicted column has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin : column_stimulus
        logic [COL_W-1:0]  base;
        logic [COL_W-1:0]  col;
        logic [FUNC_W-1:0] fn;
        int                pick;
        int                first_random;
        int                next_drain;
        int                i;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.func   <= FUNC_LOAD;
        in_ch.column <= '0;
        in_ch.elem_x <= '0;
        in_ch.elem_y <= '0;
        in_ch.elem_z <= '0;
        in_ch.elem_w <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity after reset: products echo the vector
        send_beat(FUNC_MUL, 2'd0, ELEM_HI, ELEM_LO, '0, 32'sd1);
        send_beat(FUNC_MUL, 2'd1, -32'sd1, UNITY, -UNITY, 32'sh1234_5678);
        send_beat(FUNC_MUL, 2'd2, 32'sh0000_8000, 32'shffff_8000, ELEM_HI, ELEM_LO);
        send_rand(FUNC_MUL, 2'd3);
        send_beat(FUNC_COMMIT, 2'd0, UNITY, '0, '0, '0);
        send_beat(FUNC_SPARE, 2'd2, '1, '1, '1, '1);
        // all-max matrix: clamps high and low
        for (i = 0; i < DIM; i++) begin
            send_beat(FUNC_LOAD, COL_W'(i), ELEM_HI, ELEM_HI, ELEM_HI, ELEM_HI);
        end
        send_beat(FUNC_MUL, 2'd1, ELEM_HI, ELEM_HI, ELEM_HI, ELEM_HI);
        send_beat(FUNC_MUL, 2'd2, ELEM_LO, ELEM_LO, ELEM_LO, ELEM_LO);
        send_beat(FUNC_MUL, 2'd3, ELEM_LO, ELEM_HI, '0, '0);
        // all-min matrix: the largest possible sum of products
        for (i = 0; i < DIM; i++) begin
            send_beat(FUNC_LOAD, COL_W'(i), ELEM_LO, ELEM_LO, ELEM_LO, ELEM_LO);
        end
        send_beat(FUNC_MUL, 2'd0, ELEM_LO, ELEM_LO, ELEM_LO, ELEM_LO);
        // tiny negative product must round toward minus infinity
        send_beat(FUNC_LOAD, 2'd0, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
        send_beat(FUNC_MUL, 2'd1, -32'sd1, '0, '0, '0);
        send_beat(FUNC_COMMIT, 2'd2, UNITY, UNITY, UNITY, UNITY);
        send_rand(FUNC_SPARE, 2'd3);
        send_beat(FUNC_LOAD, 2'd1, '0, '0, '0, '0);
        drain_results();

        first_random = beats_sent;
        next_drain   = beats_sent + DRAIN_EVERY;
        while (beats_sent < first_random + RANDOM_BEATS) begin
            if (beats_sent >= next_drain) begin
                drain_results();
                next_drain += DRAIN_EVERY;
            end
            if (!hold_request && beats_sent - first_random >= STALL_AT_BEAT)
                hold_request = 1'b1;
            pick = $urandom_range(0, 99);
            base = COL_W'($urandom_range(0, 3));
            if (pick < 20) begin
                for (i = 0; i < DIM; i++) send_rand(FUNC_LOAD, COL_W'(base + i));
            end else if (pick < 50) begin
                repeat ($urandom_range(1, 8)) send_rand(FUNC_MUL, COL_W'($urandom_range(0, 3)));
            end else if (pick < 80) begin
                // full right-hand matrix, committed on its last column
                for (i = 0; i < DIM - 1; i++) send_rand(FUNC_MUL, COL_W'(base + i));
                send_rand(FUNC_COMMIT, COL_W'(base + DIM - 1));
            end else if (pick < 97) begin
                fn  = FUNC_W'($urandom_range(0, 2));
                col = COL_W'($urandom_range(0, 3));
                if (fn == FUNC_COMMIT && !commit_allowed(col)) fn = FUNC_MUL;
                send_rand(fn, col);
            end else begin
                send_rand(FUNC_SPARE, COL_W'($urandom_range(0, 3)));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : result_stalls
        bit level;
        bit hold_served;
        int span;
        level       = 1'b0;
        hold_served = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_served) begin
                // long hold-off so the block fills and stalls its input
                hold_served = 1'b1;
                level       = 1'b0;
                span        = HOLD_CYCLES;
            end else if (level) begin
                level = 1'b0;
                span  = idle_len();
            end else begin
                level = 1'b1;
                span  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                    : $urandom_range(1, 8);
            end
            out_ch.ready <= level;
            repeat (span - 1) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule
